[hw/rtl/eikcu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eikcu_pkg
// Shared widths, register indexes and pipeline record types of the eikonal
// cell update block.
// ----------------------------------------------------------------------------
package eikcu_pkg;

   // field and datapath widths
   localparam int VALUE_W  = 32;  // signed q16.16 distance
   localparam int INDEX_W  = 10;  // column and row index
   localparam int DIM_W    = 11;  // grid extent registers
   localparam int SPACE_W  = 31;  // spacing and inverse spacing registers
   localparam int GUESS_W  = 34;  // first guess and final sum before saturation
   localparam int DIFF_W   = 33;  // magnitude of the axis difference
   localparam int SQ_W     = 25;  // low part of the difference that may square below q
   localparam int RAD_W    = 50;  // radicand of the square root
   localparam int ROOT_W   = 25;  // integer square root of the radicand
   localparam int REM_W    = 27;  // square root partial remainder
   localparam int QUOT1_W  = 49;  // floor(2^48 / r)
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 152;
   localparam int RSP_DATA_W = 32;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_GRID_SPACING   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INV_SPACING_SQ = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_WIDTH     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_HEIGHT    = 2'd3;

   // register reset values
   localparam logic [SPACE_W-1:0] GRID_SPACING_RST   = 31'd65536;
   localparam logic [SPACE_W-1:0] INV_SPACING_SQ_RST = 31'd65536;
   localparam logic [DIM_W-1:0]   GRID_WIDTH_RST     = 11'd1024;
   localparam logic [DIM_W-1:0]   GRID_HEIGHT_RST    = 11'd1024;

   // status codes
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_NO_NBR = 1'b1;

   // saturation bounds at the guess width
   localparam logic signed [GUESS_W-1:0] SAT_MAX = 34'sd2147483647;
   localparam logic signed [GUESS_W-1:0] SAT_MIN = -34'sd2147483648;

   // per-item record that travels beside the square root
   typedef struct packed {
      logic signed [VALUE_W-1:0] x;
      logic signed [VALUE_W-1:0] y;
      logic                      two_axes;
      logic signed [GUESS_W-1:0] guess;
      logic                      root_ok;
      logic                      no_nbr;
   } side_type;

   // quotients of n * 2^48 by the inverse spacing, floor and ceiling
   typedef struct packed {
      logic [RAD_W-1:0] q1_floor;
      logic [RAD_W-1:0] q1_ceil;
      logic [RAD_W-1:0] q2_floor;
      logic [RAD_W-1:0] q2_ceil;
   } recip_type;

endpackage

[hw/rtl/eikcu_recip.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eikcu_recip
// Bit-serial divider that forms floor and ceiling of 2^48 / r and 2^49 / r
// for the root test, rerun after reset and after each inverse spacing write.
// ----------------------------------------------------------------------------
module eikcu_recip (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [eikcu_pkg::SPACE_W-1:0]     divisor,
   output logic                              busy,
   output eikcu_pkg::recip_type              quot
);

   localparam int STEPS   = eikcu_pkg::QUOT1_W;
   localparam int COUNT_W = $clog2(STEPS);
   localparam int DW      = eikcu_pkg::SPACE_W;
   localparam int QW      = eikcu_pkg::QUOT1_W;
   localparam int RW      = eikcu_pkg::RAD_W;
   localparam logic [COUNT_W-1:0] LAST_STEP = COUNT_W'(STEPS - 1);

   // divider states
   localparam logic [1:0] DIV_IDLE   = 2'd0;
   localparam logic [1:0] DIV_RUN    = 2'd1;
   localparam logic [1:0] DIV_FINISH = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [DW-1:0]      rem_ff, rem_in;
   logic [QW-1:0]      q_ff, q_in;
   eikcu_pkg::recip_type quot_ff, quot_in;

   logic [DW:0]   rem_shift;
   logic          step_ge;
   logic [DW:0]   rem_sub;
   logic [DW:0]   rem_dbl;
   logic          dbl_ge;
   logic [DW:0]   rem2;
   logic [RW-1:0] q2;

   // one restoring step: numerator is a one followed by zeros
   always_comb begin
      rem_shift = {rem_ff, (count_ff == '0)};
      step_ge   = rem_shift >= {1'b0, divisor};
      rem_sub   = rem_shift - {1'b0, divisor};
   end

   // the doubled quotient follows from the first with one more step
   always_comb begin
      rem_dbl = {rem_ff, 1'b0};
      dbl_ge  = rem_dbl >= {1'b0, divisor};
      rem2    = dbl_ge ? rem_dbl - {1'b0, divisor} : rem_dbl;
      q2      = {q_ff, dbl_ge};
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      quot_in  = quot_ff;
      case (state_ff)
         DIV_RUN: begin
            rem_in   = step_ge ? rem_sub[DW-1:0] : rem_shift[DW-1:0];
            q_in     = {q_ff[QW-2:0], step_ge};
            count_in = count_ff + 1'b1;
            if (count_ff == LAST_STEP) begin
               state_in = DIV_FINISH;
            end
         end
         DIV_FINISH: begin
            quot_in.q1_floor = {1'b0, q_ff};
            quot_in.q1_ceil  = {1'b0, q_ff} + RW'(rem_ff != '0);
            quot_in.q2_floor = q2;
            quot_in.q2_ceil  = q2 + RW'(rem2 != '0);
            state_in         = DIV_IDLE;
         end
         default: begin
         end
      endcase
      if (start) begin
         state_in = DIV_RUN;
         count_in = '0;
         rem_in   = '0;
         q_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_RUN;
         count_ff <= '0;
         rem_ff   <= '0;
         q_ff     <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rem_ff   <= rem_in;
         q_ff     <= q_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
   end

   assign busy = state_ff != DIV_IDLE;
   assign quot = quot_ff;

endmodule

[hw/rtl/eikcu_sqrt_pipe.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eikcu_sqrt_pipe
// Pipelined integer square root, one result bit per stage, with the item
// record carried alongside; all stages move together on enable.
// ----------------------------------------------------------------------------
module eikcu_sqrt_pipe (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             enable,
   input  logic                             in_valid,
   input  logic [eikcu_pkg::RAD_W-1:0]      in_radicand,
   input  eikcu_pkg::side_type              in_side,
   output logic                             out_valid,
   output logic [eikcu_pkg::ROOT_W-1:0]     out_root,
   output eikcu_pkg::side_type              out_side
);

   localparam int STEPS  = eikcu_pkg::ROOT_W;
   localparam int RADW   = eikcu_pkg::RAD_W;
   localparam int ROOTW  = eikcu_pkg::ROOT_W;
   localparam int REMW   = eikcu_pkg::REM_W;
   localparam int WORK_W = REMW + 2;

   logic                 valid_ff [STEPS];
   logic [RADW-1:0]      rad_ff  [STEPS];
   logic [ROOTW-1:0]     root_ff [STEPS];
   logic [REMW-1:0]      rem_ff  [STEPS];
   eikcu_pkg::side_type  side_ff [STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic                 prev_valid;
      logic [RADW-1:0]      prev_rad;
      logic [ROOTW-1:0]     prev_root;
      logic [REMW-1:0]      prev_rem;
      eikcu_pkg::side_type  prev_side;
      logic [WORK_W-1:0]    work;
      logic [WORK_W-1:0]    trial;
      logic [WORK_W-1:0]    diff;
      logic                 ge;

      if (i == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_rad   = in_radicand;
         assign prev_root  = '0;
         assign prev_rem   = '0;
         assign prev_side  = in_side;
      end else begin : g_next
         assign prev_valid = valid_ff[i-1];
         assign prev_rad   = rad_ff[i-1];
         assign prev_root  = root_ff[i-1];
         assign prev_rem   = rem_ff[i-1];
         assign prev_side  = side_ff[i-1];
      end

      // bring down the next two radicand bits and try root*4+1
      always_comb begin
         work  = {prev_rem, prev_rad[RADW-1 -: 2]};
         trial = {2'b00, prev_root, 2'b01};
         ge    = work >= trial;
         diff  = work - trial;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (enable) begin
            valid_ff[i] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rad_ff[i]  <= {prev_rad[RADW-3:0], 2'b00};
            root_ff[i] <= {prev_root[ROOTW-2:0], ge};
            rem_ff[i]  <= ge ? diff[REMW-1:0] : work[REMW-1:0];
            side_ff[i] <= prev_side;
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_root  = root_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

[hw/rtl/eikonal_cell_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eikonal_cell_update
// First-order upwind eikonal update of one grid cell in signed q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one cell per item: its column and row, four neighbour
//   distances and their known flags. rsp_* returns one item per cell: the
//   saturated distance in tdata and the status flag in tuser (set when no
//   neighbour counts, distance then zero).
//   csr_* writes the spacing, inverse spacing squared and grid extent; write
//   only while no item is in flight.
// Throughput and pipeline:
//   one item per cycle sustained while rsp_tready is high and no divider run
//   is under way; four setup stages, 25 square root stages and one output
//   stage lie from req accept to rsp valid, set by the one-bit-per-stage square root.
// Reset and configuration:
//   after reset, and after each inverse spacing write, a serial divider runs
//   to form 2^48/r and 2^49/r; req_tready is low meanwhile.
// Stall:
//   when rsp_tready is low with a result waiting, the whole pipeline holds
//   and req_tready drops; no item is lost or repeated.
// ----------------------------------------------------------------------------
module eikonal_cell_update #(
   parameter int MAX_GRID_DIM = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // cell in: column_index, row_index, left_value, left_known, right_value,
   //          right_known, below_value, below_known, above_value, above_known
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [eikcu_pkg::REQ_DATA_W-1:0]     req_tdata,
   // result out: distance
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [eikcu_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // result flag: status
   output logic                                 rsp_tuser,
   // register write
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [eikcu_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [eikcu_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int VW    = eikcu_pkg::VALUE_W;
   localparam int GW    = eikcu_pkg::GUESS_W;
   localparam int DFW   = eikcu_pkg::DIFF_W;
   localparam int SQW   = eikcu_pkg::SQ_W;
   localparam int RADW  = eikcu_pkg::RAD_W;
   localparam int ROOTW = eikcu_pkg::ROOT_W;
   localparam int IW    = eikcu_pkg::INDEX_W;
   localparam int DW    = eikcu_pkg::DIM_W;
   localparam int SW    = eikcu_pkg::SPACE_W;
   localparam int CLOG_DIM = $clog2(MAX_GRID_DIM + 1);
   localparam int EXT_W    = (CLOG_DIM > DW) ? CLOG_DIM : DW;
   localparam logic [EXT_W-1:0] MAX_DIM = EXT_W'(MAX_GRID_DIM);

   // configuration registers
   logic [SW-1:0] grid_spacing_ff;
   logic [SW-1:0] inv_spacing_sq_ff;
   logic [DW-1:0] grid_width_ff;
   logic [DW-1:0] grid_height_ff;
   logic          csr_fire;
   logic          recip_start;
   logic          recip_busy;
   eikcu_pkg::recip_type recip_q;

   assign csr_ready   = 1'b1;
   assign csr_fire    = csr_valid && csr_ready;
   assign recip_start = csr_fire && (csr_index == eikcu_pkg::REG_INV_SPACING_SQ);

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_spacing_ff   <= eikcu_pkg::GRID_SPACING_RST;
         inv_spacing_sq_ff <= eikcu_pkg::INV_SPACING_SQ_RST;
         grid_width_ff     <= eikcu_pkg::GRID_WIDTH_RST;
         grid_height_ff    <= eikcu_pkg::GRID_HEIGHT_RST;
      end else if (csr_fire) begin
         case (csr_index)
            eikcu_pkg::REG_GRID_SPACING:   grid_spacing_ff   <= csr_data[SW-1:0];
            eikcu_pkg::REG_INV_SPACING_SQ: inv_spacing_sq_ff <= csr_data[SW-1:0];
            eikcu_pkg::REG_GRID_WIDTH:     grid_width_ff     <= csr_data[DW-1:0];
            eikcu_pkg::REG_GRID_HEIGHT:    grid_height_ff    <= csr_data[DW-1:0];
            default: begin
            end
         endcase
      end
   end

   eikcu_recip u_recip (
      .clock   (clock),
      .reset   (reset),
      .start   (recip_start),
      .divisor (inv_spacing_sq_ff),
      .busy    (recip_busy),
      .quot    (recip_q)
   );

   // global pipeline advance
   logic adv;
   logic req_fire;
   logic rsp_valid_ff;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv && !recip_busy;
   assign req_fire   = req_tvalid && req_tready;

   // unpack the cell item
   logic [IW-1:0]        col;
   logic [IW-1:0]        row;
   logic signed [VW-1:0] left_v, right_v, below_v, above_v;
   logic                 left_k, right_k, below_k, above_k;

   assign col     = req_tdata[9:0];
   assign row     = req_tdata[19:10];
   assign left_v  = req_tdata[51:20];
   assign left_k  = req_tdata[52];
   assign right_v = req_tdata[84:53];
   assign right_k = req_tdata[85];
   assign below_v = req_tdata[117:86];
   assign below_k = req_tdata[118];
   assign above_v = req_tdata[150:119];
   assign above_k = req_tdata[151];

   // stage 1: edge tests and axis minima
   logic [EXT_W-1:0]     ext_w, ext_h;
   logic                 l_ok, r_ok, b_ok, a_ok;
   logic                 s1_valid_ff;
   logic signed [VW-1:0] px_ff, py_ff, px_in, py_in;
   logic                 hx_ff, hy_ff;

   always_comb begin
      ext_w = (EXT_W'(grid_width_ff) < MAX_DIM) ? EXT_W'(grid_width_ff) : MAX_DIM;
      ext_h = (EXT_W'(grid_height_ff) < MAX_DIM) ? EXT_W'(grid_height_ff) : MAX_DIM;
      l_ok  = left_k && (col != '0);
      r_ok  = right_k && ((EXT_W'(col) + 1'b1) < ext_w);
      b_ok  = below_k && (row != '0);
      a_ok  = above_k && ((EXT_W'(row) + 1'b1) < ext_h);
      if (l_ok && r_ok) begin
         px_in = (left_v < right_v) ? left_v : right_v;
      end else begin
         px_in = l_ok ? left_v : right_v;
      end
      if (b_ok && a_ok) begin
         py_in = (below_v < above_v) ? below_v : above_v;
      end else begin
         py_in = b_ok ? below_v : above_v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff <= px_in;
         py_ff <= py_in;
         hx_ff <= l_ok || r_ok;
         hy_ff <= b_ok || a_ok;
      end
   end

   // stage 2: axis values, first guess, difference magnitude
   eikcu_pkg::side_type s2_side_in, s2_side_ff;
   logic                s2_valid_ff;
   logic [DFW-1:0]      ad_in, ad_ff;
   logic signed [GW-1:0] h_ext, gx, gy, gsel;
   logic signed [DFW-1:0] diff;

   always_comb begin
      s2_side_in.two_axes = hx_ff && hy_ff;
      s2_side_in.no_nbr   = !hx_ff && !hy_ff;
      s2_side_in.root_ok  = 1'b0;
      s2_side_in.x        = hx_ff ? px_ff : py_ff;
      s2_side_in.y        = (hx_ff && hy_ff) ? py_ff : s2_side_in.x;
      h_ext = $signed({{(GW-SW){1'b0}}, grid_spacing_ff});
      gx    = GW'(px_ff) + h_ext;
      gy    = GW'(py_ff) + h_ext;
      gsel  = GW'(s2_side_in.x) + h_ext;
      s2_side_in.guess = s2_side_in.two_axes ? ((gx > gy) ? gx : gy) : gsel;
      diff  = DFW'(s2_side_in.x) - DFW'(s2_side_in.y);
      ad_in = diff[DFW-1] ? DFW'(-diff) : DFW'(diff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_side_ff <= s2_side_in;
         ad_ff      <= ad_in;
      end
   end

   // stage 3: square of the difference; a wide one can never pass the test
   eikcu_pkg::side_type s3_side_ff;
   logic                s3_valid_ff;
   logic [RADW-1:0]     d2_ff;
   logic                big_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_side_ff <= s2_side_ff;
         big_ff     <= |ad_ff[DFW-1:SQW];
         d2_ff      <= RADW'(ad_ff[SQW-1:0]) * RADW'(ad_ff[SQW-1:0]);
      end
   end

   // stage 4: discriminant test and radicand
   eikcu_pkg::side_type s4_side_in, s4_side_ff;
   logic                s4_valid_ff;
   logic [RADW-1:0]     q_floor, q_ceil, rad_in, rad_ff;

   always_comb begin
      q_floor = s3_side_ff.two_axes ? recip_q.q2_floor : recip_q.q1_floor;
      q_ceil  = s3_side_ff.two_axes ? recip_q.q2_ceil : recip_q.q1_ceil;
      rad_in  = q_floor - d2_ff;
      s4_side_in         = s3_side_ff;
      s4_side_in.root_ok = !s3_side_ff.no_nbr && (inv_spacing_sq_ff != '0)
                           && !big_ff && (d2_ff < q_ceil);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_side_ff <= s4_side_in;
         rad_ff     <= rad_in;
      end
   end

   // stages 5 to 29: square root
   logic                sq_valid;
   logic [ROOTW-1:0]    sq_root;
   eikcu_pkg::side_type sq_side;

   eikcu_sqrt_pipe u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .enable      (adv),
      .in_valid    (s4_valid_ff),
      .in_radicand (rad_ff),
      .in_side     (s4_side_ff),
      .out_valid   (sq_valid),
      .out_root    (sq_root),
      .out_side    (sq_side)
   );

   // output stage: form the root solution and saturate
   logic signed [GW-1:0] v_ext, sum2, sum1, root_sol, sol, sat;
   logic [VW-1:0]        dist_in;
   logic [VW-1:0]        rsp_data_ff;
   logic                 rsp_user_ff;

   always_comb begin
      v_ext    = $signed({{(GW-ROOTW){1'b0}}, sq_root});
      sum2     = GW'(sq_side.x) + GW'(sq_side.y) + v_ext;
      sum1     = GW'(sq_side.x) + v_ext;
      root_sol = sq_side.two_axes ? (sum2 >>> 1) : sum1;
      sol      = sq_side.root_ok ? root_sol : sq_side.guess;
      if (sol > eikcu_pkg::SAT_MAX) begin
         sat = eikcu_pkg::SAT_MAX;
      end else if (sol < eikcu_pkg::SAT_MIN) begin
         sat = eikcu_pkg::SAT_MIN;
      end else begin
         sat = sol;
      end
      dist_in = sq_side.no_nbr ? '0 : sat[VW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= dist_in;
         rsp_user_ff <= sq_side.no_nbr ? eikcu_pkg::STATUS_NO_NBR : eikcu_pkg::STATUS_OK;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for eikonal_cell_update. A queue of cells feeds a
// stream driver. Each accepted cell is solved by an integer model of the
// upwind update at the current grid settings. A monitor checks every
// returned distance and status against the oldest open prediction. The run
// steps through several grid settings, including the register extremes and a
// zero inverse spacing, with random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;

   localparam int    CLOCK_HALF   = 6;
   localparam int    GRID_DIM_MAX = 1024;
   localparam int    DRAIN_CYCLES = 40;
   localparam int    REPORT_LIMIT = 10;
   localparam longint DIST_MAX    = 64'sd2147483647;
   localparam longint DIST_MIN    = -64'sd2147483648;

   // idling phases of the run
   localparam int PHASE_SENDER_IDLE   = 0;
   localparam int PHASE_RECEIVER_IDLE = 1;
   localparam int PHASE_NO_IDLE       = 2;

   // neighbour slots of one cell
   typedef enum int {
      NBR_LEFT  = 0,
      NBR_RIGHT = 1,
      NBR_BELOW = 2,
      NBR_ABOVE = 3
   } nbr_type;

   typedef struct packed {
      logic [3:0][eikcu_pkg::VALUE_W-1:0] value;
      logic [3:0]                         known;
      logic [eikcu_pkg::INDEX_W-1:0]      row;
      logic [eikcu_pkg::INDEX_W-1:0]      column;
   } cell_type;

   typedef struct packed {
      logic [eikcu_pkg::VALUE_W-1:0] distance;
      logic                          status;
   } result_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [eikcu_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [eikcu_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                             rsp_tuser;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [eikcu_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [eikcu_pkg::CSR_DATA_W-1:0] csr_data = '0;

   // register shadow used by the solver
   logic [eikcu_pkg::SPACE_W-1:0] spacing_reg = eikcu_pkg::GRID_SPACING_RST;
   logic [eikcu_pkg::SPACE_W-1:0] inv_sq_reg  = eikcu_pkg::INV_SPACING_SQ_RST;
   logic [eikcu_pkg::DIM_W-1:0]   width_reg   = eikcu_pkg::GRID_WIDTH_RST;
   logic [eikcu_pkg::DIM_W-1:0]   height_reg  = eikcu_pkg::GRID_HEIGHT_RST;

   cell_type   pending_cells[$];
   result_type awaited_results[$];
   cell_type   cell_on_bus;
   result_type got_result;
   result_type want_result;
   result_type check_result;

   // spread of neighbour values that still leaves a real root, about 1.4 at reset
   longint close_span = 64'd92681;
   int     cells_sent = 0;
   int     results_checked = 0;
   int     no_nbr_count = 0;
   int     settings_run = 1;
   int     failures = 0;

   eikonal_cell_update #(
      .MAX_GRID_DIM(GRID_DIM_MAX)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // integer square root, rounded down
   function automatic longint unsigned floor_sqrt(input longint unsigned v);
      longint unsigned root;
      longint unsigned bitv;
      longint unsigned rest;
      root = 0;
      rest = v;
      bitv = 64'd1 << 62;
      while (bitv > rest) bitv >>= 2;
      while (bitv != 0) begin
         if (rest >= root + bitv) begin
            rest -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic longint clip_extent(input logic [eikcu_pkg::DIM_W-1:0] reg_value);
      return (reg_value < GRID_DIM_MAX) ? longint'(reg_value) : longint'(GRID_DIM_MAX);
   endfunction

   // upwind update of one cell at the current settings
   function automatic result_type solve_cell_distance(input cell_type c);
      result_type res;
      longint col, row, w_ext, h_ext;
      longint lv, rv, bv, av;
      longint px, py, x, y, sol, v, h;
      longint unsigned ad, d2, q, rem, n, r;
      logic cl, cr, cb, ca, has_x, has_y;
      col   = longint'(c.column);
      row   = longint'(c.row);
      w_ext = clip_extent(width_reg);
      h_ext = clip_extent(height_reg);
      lv = longint'($signed(c.value[NBR_LEFT]));
      rv = longint'($signed(c.value[NBR_RIGHT]));
      bv = longint'($signed(c.value[NBR_BELOW]));
      av = longint'($signed(c.value[NBR_ABOVE]));
      // a neighbour counts only when known and on the grid
      cl = c.known[NBR_LEFT] && col > 0;
      cr = c.known[NBR_RIGHT] && col + 1 < w_ext;
      cb = c.known[NBR_BELOW] && row > 0;
      ca = c.known[NBR_ABOVE] && row + 1 < h_ext;
      has_x = cl || cr;
      has_y = cb || ca;
      res.status = eikcu_pkg::STATUS_OK;
      if (!has_x && !has_y) begin
         res.distance = '0;
         res.status   = eikcu_pkg::STATUS_NO_NBR;
         return res;
      end
      px = (cl && cr) ? ((lv < rv) ? lv : rv) : (cl ? lv : rv);
      py = (cb && ca) ? ((bv < av) ? bv : av) : (cb ? bv : av);
      h  = longint'(spacing_reg);
      // first guess from the larger one-sided step
      if (has_x && has_y) begin
         sol = (px + h > py + h) ? px + h : py + h;
         x = px;
         y = py;
         n = 2;
      end else begin
         x = has_x ? px : py;
         y = x;
         sol = x + h;
         n = 1;
      end
      // quadratic root when the discriminant is positive
      r = longint'(inv_sq_reg);
      if (r != 0) begin
         ad  = (x >= y) ? longint'(x - y) : longint'(y - x);
         d2  = ad * ad;
         q   = (n << 48) / r;
         rem = (n << 48) % r;
         if (d2 < q || (d2 == q && rem != 0)) begin
            v = longint'(floor_sqrt(q - d2));
            if (n == 2) sol = (x + y + v) >>> 1;
            else sol = x + v;
         end
      end
      if (sol > DIST_MAX) sol = DIST_MAX;
      if (sol < DIST_MIN) sol = DIST_MIN;
      res.distance = sol[eikcu_pkg::VALUE_W-1:0];
      return res;
   endfunction

   // receiver sparse first, then sender sparse, then no idling
   function automatic int idle_phase();
      if (cells_sent < 620) return PHASE_SENDER_IDLE;
      if (cells_sent < 1240) return PHASE_RECEIVER_IDLE;
      return PHASE_NO_IDLE;
   endfunction

   function automatic logic sender_pauses();
      case (idle_phase())
         PHASE_SENDER_IDLE:   return $urandom_range(0, 99) < 34;
         PHASE_RECEIVER_IDLE: return $urandom_range(0, 99) < 82;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic receiver_pauses();
      case (idle_phase())
         PHASE_SENDER_IDLE:   return $urandom_range(0, 99) < 82;
         PHASE_RECEIVER_IDLE: return $urandom_range(0, 99) < 34;
         default: return 1'b0;
      endcase
   endfunction

   task automatic note_failure(input string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("%s", msg);
   endtask

   // stream driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            want_result = solve_cell_distance(cell_on_bus);
            if (want_result.status == eikcu_pkg::STATUS_NO_NBR) no_nbr_count++;
            awaited_results.push_back(want_result);
            cells_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_cells.size() != 0 && !sender_pauses()) begin
               cell_on_bus = pending_cells.pop_front();
               req_tdata <= {cell_on_bus.known[NBR_ABOVE], cell_on_bus.value[NBR_ABOVE],
                             cell_on_bus.known[NBR_BELOW], cell_on_bus.value[NBR_BELOW],
                             cell_on_bus.known[NBR_RIGHT], cell_on_bus.value[NBR_RIGHT],
                             cell_on_bus.known[NBR_LEFT], cell_on_bus.value[NBR_LEFT],
                             cell_on_bus.row, cell_on_bus.column};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_result.distance = rsp_tdata;
            got_result.status   = rsp_tuser;
            if (awaited_results.size() == 0) begin
               note_failure($sformatf("unexpected result: distance %h status %0d",
                                      got_result.distance, got_result.status));
            end else begin
               check_result = awaited_results.pop_front();
               if (got_result.distance !== check_result.distance ||
                   got_result.status !== check_result.status)
                  note_failure($sformatf(
                     "result %0d: distance exp %h got %h, status exp %0d got %0d",
                     results_checked, check_result.distance, got_result.distance,
                     check_result.status, got_result.status));
            end
            results_checked++;
         end
         rsp_tready <= !receiver_pauses();
      end
   end

   task automatic push_cell(input int col, input int row,
                            input logic [31:0] lv, input logic lk,
                            input logic [31:0] rv, input logic rk,
                            input logic [31:0] bv, input logic bk,
                            input logic [31:0] av, input logic ak);
      cell_type c;
      c.column = col[eikcu_pkg::INDEX_W-1:0];
      c.row    = row[eikcu_pkg::INDEX_W-1:0];
      c.value[NBR_LEFT]  = lv;
      c.value[NBR_RIGHT] = rv;
      c.value[NBR_BELOW] = bv;
      c.value[NBR_ABOVE] = av;
      c.known = {ak, bk, rk, lk};
      pending_cells.push_back(c);
   endtask

   // index at or near the grid boundary
   function automatic logic [eikcu_pkg::INDEX_W-1:0] edge_pick(input longint ext);
      longint idx;
      case ($urandom_range(0, 3))
         0: idx = 0;
         1: idx = ext - 1;
         2: idx = (ext > 1023) ? 1023 : ext;
         default: idx = ext - 2;
      endcase
      return idx[eikcu_pkg::INDEX_W-1:0];
   endfunction

   // mostly neighbours close together so that a real root exists
   function automatic cell_type random_cell();
      cell_type c;
      longint w_ext, h_ext, base, v;
      int unsigned pick, style;
      w_ext = clip_extent(width_reg);
      h_ext = clip_extent(height_reg);
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         c.column = eikcu_pkg::INDEX_W'($urandom_range(0, w_ext - 1));
         c.row    = eikcu_pkg::INDEX_W'($urandom_range(0, h_ext - 1));
      end else if (pick < 8) begin
         c.column = edge_pick(w_ext);
         c.row    = edge_pick(h_ext);
      end else begin
         c.column = eikcu_pkg::INDEX_W'($urandom_range(0, 1023));
         c.row    = eikcu_pkg::INDEX_W'($urandom_range(0, 1023));
      end
      if ($urandom_range(0, 4) == 0) begin
         c.known = 4'($urandom_range(0, 15));
      end else begin
         for (int k = 0; k < 4; k++) c.known[k] = ($urandom_range(0, 3) != 0);
      end
      case ($urandom_range(0, 3))
         0: base = longint'($urandom_range(0, 1 << 24)) - (1 << 20);
         1: base = longint'($signed(32'($urandom)));
         2: base = DIST_MAX - longint'($urandom_range(0, close_span));
         default: base = DIST_MIN + longint'($urandom_range(0, close_span));
      endcase
      style = $urandom_range(0, 9);
      for (int k = 0; k < 4; k++) begin
         if (style < 7) begin
            v = base + longint'($urandom_range(0, 2 * close_span)) - close_span;
         end else if (style < 9) begin
            v = longint'($urandom);
         end else begin
            case ($urandom_range(0, 3))
               0: v = DIST_MAX;
               1: v = DIST_MIN;
               2: v = 0;
               default: v = -1;
            endcase
         end
         c.value[k] = v[eikcu_pkg::VALUE_W-1:0];
      end
      return c;
   endfunction

   task automatic add_random_cells(input int count);
      for (int i = 0; i < count; i++) pending_cells.push_back(random_cell());
   endtask

   task automatic wait_drained();
      while (pending_cells.size() != 0 || req_tvalid || awaited_results.size() != 0)
         @(posedge clock);
   endtask

   // one register write, valid stays up for a following write
   task automatic write_reg(input logic [eikcu_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         eikcu_pkg::REG_GRID_SPACING:   spacing_reg = value[eikcu_pkg::SPACE_W-1:0];
         eikcu_pkg::REG_INV_SPACING_SQ: inv_sq_reg  = value[eikcu_pkg::SPACE_W-1:0];
         eikcu_pkg::REG_GRID_WIDTH:     width_reg   = value[eikcu_pkg::DIM_W-1:0];
         default:                       height_reg  = value[eikcu_pkg::DIM_W-1:0];
      endcase
   endtask

   task automatic set_grid(input longint spacing, input longint inv_sq,
                           input int cols, input int rows);
      longint w;
      write_reg(eikcu_pkg::REG_GRID_SPACING, spacing[31:0]);
      write_reg(eikcu_pkg::REG_INV_SPACING_SQ, inv_sq[31:0]);
      write_reg(eikcu_pkg::REG_GRID_WIDTH, 32'(cols));
      write_reg(eikcu_pkg::REG_GRID_HEIGHT, 32'(rows));
      csr_valid <= 1'b0;
      // value window that keeps the discriminant positive
      if (inv_sq_reg == 0) begin
         close_span = 1 << 20;
      end else begin
         w = longint'(floor_sqrt((64'd2 << 48) / inv_sq_reg));
         close_span = (w > (1 << 30)) ? (1 << 30) : w;
      end
      settings_run++;
   endtask

   // stimulus sequence
   initial begin
      longint h;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: unit spacing on the full grid
      push_cell(10, 10, 0, 0, 0, 0, 0, 0, 0, 0);
      push_cell(10, 10, 0, 1, 0, 1, 0, 1, 0, 1);
      push_cell(0, 7, 32'h0001_0000, 1, 0, 0, 0, 0, 0, 0);
      push_cell(1023, 7, 0, 0, 32'h0001_0000, 1, 0, 0, 0, 0);
      push_cell(7, 0, 0, 0, 0, 0, 32'h0001_0000, 1, 0, 0);
      push_cell(7, 1023, 0, 0, 0, 0, 0, 0, 32'h0001_0000, 1);
      push_cell(5, 5, 0, 1, 0, 0, 0, 0, 0, 0);
      push_cell(5, 5, 0, 0, 32'h7FFF_FFFF, 1, 0, 0, 0, 0);
      push_cell(5, 5, 32'h8000_0000, 1, 32'h8000_0000, 1, 32'h8000_0000, 1,
                32'h8000_0000, 1);
      push_cell(5, 5, 32'h0000_0000, 1, 0, 0, 32'h000A_0000, 1, 0, 0);
      push_cell(100, 200, 32'h0003_0000, 1, 32'h0002_0000, 1, 32'h0002_8000, 1,
                32'h0009_0000, 1);
      push_cell(100, 200, 32'h0001_0000, 1, 32'h0004_0000, 1, 0, 0, 32'h0001_4000, 1);
      push_cell(1023, 1023, 32'h0001_0000, 1, 32'h0001_0000, 1, 32'h0001_0000, 1,
                32'h0001_0000, 1);
      push_cell(341, 682, 32'hAAAA_AAAA, 1, 32'h5555_5555, 1, 32'hAAAA_AAAA, 1,
                32'h5555_5555, 1);
      push_cell(682, 341, 32'h5555_5555, 1, 32'hFFFF_FFFF, 1, 32'h5555_5555, 1,
                32'hFFFF_FFFF, 1);
      push_cell(3, 3, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 1,
                32'hFFFF_FFFF, 0);
      push_cell(50, 60, 32'hFFFB_0000, 1, 32'hFFFB_8000, 1, 32'hFFFA_C000, 1,
                32'h0003_0000, 1);
      push_cell(50, 60, 32'h7FFF_FFFF, 1, 0, 0, 32'h7FFF_FFFF, 1, 0, 0);
      push_cell(50, 60, 32'h7FFF_FFFF, 1, 0, 0, 32'h8000_0000, 1, 0, 0);
      add_random_cells(300);
      wait_drained();

      // largest spacing, smallest inverse, smallest grid
      set_grid(64'h7FFF_FFFF, 1, 2, 2);
      add_random_cells(150);
      wait_drained();

      // smallest spacing, largest inverse, thin grid
      set_grid(1, 64'h7FFF_FFFF, 1024, 3);
      add_random_cells(200);
      wait_drained();

      // half spacing on an odd width
      set_grid(64'h0000_8000, 64'h0004_0000, 37, 1024);
      add_random_cells(300);
      wait_drained();

      // zero inverse spacing leaves only the first guess
      set_grid($urandom_range(1, 32'h7FFF_FFFF), 0, $urandom_range(2, 1024),
               $urandom_range(2, 1024));
      add_random_cells(100);
      wait_drained();

      // fully random registers
      set_grid($urandom_range(1, 32'h7FFF_FFFF), $urandom_range(1, 32'h7FFF_FFFF),
               $urandom_range(2, 1024), $urandom_range(2, 1024));
      add_random_cells(300);
      wait_drained();

      // unit spacing, two rows
      set_grid(64'h0001_0000, 64'h0001_0000, 1024, 2);
      add_random_cells(300);
      wait_drained();

      // consistent spacing and inverse square
      h = longint'($urandom_range(1 << 12, 1 << 20));
      set_grid(h, (64'd1 << 48) / (h * h), $urandom_range(2, 1024),
               $urandom_range(2, 1024));
      add_random_cells(200);
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (awaited_results.size() != 0)
         note_failure($sformatf("%0d results never arrived", awaited_results.size()));
      $display("%0d cells over %0d grid settings, %0d results checked",
               cells_sent, settings_run, results_checked);
      $display("%0d cells had no counted neighbour, %0d failures", no_nbr_count, failures);
      if (failures == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // hang guard
   initial begin
      #(2 * CLOCK_HALF * 400000);
      $display("timeout after %0d cells and %0d results", cells_sent, results_checked);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
